### rtl/smrcs_pkg.sv
`default_nettype none
package smrcs_pkg;

  // Matrix size limits and derived storage geometry.
  localparam int MAX_ROWS = 16;
  localparam int MAX_COLS = 16;
  localparam int CAPACITY = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int RSI_W    = $clog2(MAX_ROWS + 2);

  // Configuration register indexes.
  localparam logic REG_NUM_ROWS = 1'b0;
  localparam logic REG_NUM_COLS = 1'b1;

  // Operation codes.
  localparam logic [1:0] MODE_READ   = 2'd0;
  localparam logic [1:0] MODE_WRITE  = 2'd1;
  localparam logic [1:0] MODE_PURGE  = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [4:0]         row;
    logic [4:0]         col;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic               in_range;
    logic [8:0]         entry_total;
  } out_item_t;

  // One stored entry: its column and its value.
  typedef struct packed {
    logic [4:0]  col;
    logic [31:0] value;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

### rtl/smrcs_entry_ram.sv
`default_nettype none
module smrcs_entry_ram #(
  parameter int WIDTH = 37,
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/sparse_matrix_row_compressed_store_unit.sv
// Sparse matrix store in compressed-row form, up to 16 x 16 signed 32-bit cells.
// Input channel (in_valid, in_data, in_stall): one transaction per operation:
// read a cell, write a cell, or set the default value and purge matching entries.
// Output channel (out_valid, out_data, out_stall): one transaction per input
// transaction, in order, with the cell value, the range flag and the entry count.
// Configuration (cfg_we, cfg_index, cfg_data) sets rows and columns in use; write
// it only while the block is idle.
// A read or an overwrite reads the row's start and end pointers, then scans the
// row's entries in order. A removal or an insertion then moves every entry held
// behind it. A purge walks every row and every held entry. Every entry move is
// a read then a write through the entry memory, which has one write port and one
// registered read port; one operation is in flight at a time.
// Reset clears the row pointers, entry count and default value; the store is
// empty and sizes return to 16 x 16. A result waits in the output register while
// out_stall is high; the block may accept and work on the next transaction
// meanwhile, but holds in_stall until that result can be placed.
`default_nettype none
module sparse_matrix_row_compressed_store_unit (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire smrcs_pkg::in_item_t  in_data,
  output logic                      in_stall,
  output logic                      out_valid,
  output smrcs_pkg::out_item_t      out_data,
  input  wire logic                 out_stall,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic [4:0]           cfg_data
);
  import smrcs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RS0, S_RS1, S_SCAN, S_CHK, S_RM_RD, S_RM_WR,
    S_INS_RD, S_INS_WR, S_P_ROW, S_P_RD, S_P_WR, S_DONE
  } state_t;

  state_t            state_r;
  logic [1:0]        mode_r;
  logic [4:0]        row_r;
  logic [4:0]        col_r;
  logic [31:0]       val_r;
  logic              ok_r;
  logic [31:0]       def_r;
  logic [31:0]       rd_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  k_r;
  logic [CNT_W-1:0]  end_r;
  logic [CNT_W-1:0]  dst_r;
  logic [RSI_W-1:0]  prow_r;
  logic [CNT_W-1:0]  rs_r [MAX_ROWS+1];
  logic [4:0]        num_rows_r;
  logic [4:0]        num_cols_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic [4:0]        rows_use;
  logic [4:0]        cols_use;
  logic              in_ok;
  logic [RSI_W-1:0]  rs_idx;
  logic [CNT_W-1:0]  rs_q;
  logic [CNT_W-1:0]  raddr_full;
  logic              ram_we;
  logic [CNT_W-1:0]  waddr_full;
  entry_t            ram_wdata;
  entry_t            ram_rdata;
  logic              notfound;
  logic              out_free;

  // Entry memory: column and value of each held entry.
  smrcs_entry_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY),
    .AW   (ADDR_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr_full[ADDR_W-1:0]),
    .wdata(ram_wdata),
    .raddr(raddr_full[ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  // Sizes in use, clamped to the maximum, and the range check.
  assign rows_use = (num_rows_r > 5'(MAX_ROWS)) ? 5'(MAX_ROWS) : num_rows_r;
  assign cols_use = (num_cols_r > 5'(MAX_COLS)) ? 5'(MAX_COLS) : num_cols_r;
  assign in_ok    = (in_data.row >= 5'd1) && (in_data.row <= rows_use) &&
                    (in_data.col >= 5'd1) && (in_data.col <= cols_use);

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Single read port on the row pointers.
  always_comb begin
    unique case (state_r)
      S_RS0:   rs_idx = RSI_W'(row_r - 5'd1);
      S_RS1:   rs_idx = RSI_W'(row_r);
      S_P_ROW: rs_idx = (prow_r == RSI_W'(MAX_ROWS)) ? prow_r : prow_r + 1'b1;
      default: rs_idx = '0;
    endcase
    rs_q = rs_r[rs_idx];
  end

  // Memory read address by state.
  always_comb begin
    unique case (state_r)
      S_RM_RD:  raddr_full = k_r + 1'b1;
      S_INS_RD: raddr_full = k_r - 1'b1;
      default:  raddr_full = k_r;
    endcase
  end

  // The scan ends without a match at the row end or at a larger column.
  assign notfound = ((state_r == S_SCAN) && (k_r >= end_r)) ||
                    ((state_r == S_CHK) && (ram_rdata.col > col_r));

  // Memory write port by state.
  always_comb begin
    ram_we     = 1'b0;
    waddr_full = k_r;
    ram_wdata  = ram_rdata;
    unique case (state_r)
      S_CHK: begin
        if ((ram_rdata.col == col_r) && (mode_r == MODE_WRITE) && (val_r != def_r)) begin
          ram_we    = 1'b1;
          ram_wdata = '{col: col_r, value: val_r};
        end
      end
      S_RM_WR, S_INS_WR: begin
        ram_we = 1'b1;
      end
      S_INS_RD: begin
        if (k_r <= end_r) begin
          ram_we    = 1'b1;
          ram_wdata = '{col: col_r, value: val_r};
        end
      end
      S_P_WR: begin
        waddr_full = dst_r;
        ram_we     = (ram_rdata.value != val_r);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Sequencer, row pointers, configuration and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      def_r       <= '0;
      num_rows_r  <= 5'(MAX_ROWS);
      num_cols_r  <= 5'(MAX_COLS);
      out_valid_r <= 1'b0;
      for (int i = 0; i <= MAX_ROWS; i++) begin
        rs_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_NUM_ROWS) begin
          num_rows_r <= cfg_data;
        end else begin
          num_cols_r <= cfg_data;
        end
      end

      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mode_r <= in_data.mode;
            row_r  <= in_data.row;
            col_r  <= in_data.col;
            val_r  <= in_data.value;
            ok_r   <= in_ok;
            rd_r   <= '0;
            if (in_data.mode == MODE_PURGE) begin
              def_r  <= in_data.value;
              prow_r <= '0;
              k_r    <= '0;
              dst_r  <= '0;
              state_r <= S_P_ROW;
            end else if (in_ok && ((in_data.mode == MODE_READ) ||
                                   (in_data.mode == MODE_WRITE))) begin
              state_r <= S_RS0;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_RS0: begin
          k_r     <= rs_q;
          state_r <= S_RS1;
        end
        S_RS1: begin
          end_r   <= rs_q;
          state_r <= S_SCAN;
        end
        S_SCAN, S_CHK: begin
          if (notfound) begin
            // Cell not held: read the default, or insert at this position.
            if (mode_r == MODE_READ) begin
              rd_r    <= def_r;
              state_r <= S_DONE;
            end else if ((val_r != def_r) && (cnt_r < CNT_W'(CAPACITY))) begin
              end_r   <= k_r;
              k_r     <= cnt_r;
              state_r <= S_INS_RD;
            end else begin
              state_r <= S_DONE;
            end
          end else if (state_r == S_SCAN) begin
            state_r <= S_CHK;
          end else if (ram_rdata.col == col_r) begin
            // Cell held: read it, overwrite it, or remove it.
            if (mode_r == MODE_READ) begin
              rd_r    <= ram_rdata.value;
              state_r <= S_DONE;
            end else if (val_r == def_r) begin
              state_r <= S_RM_RD;
            end else begin
              state_r <= S_DONE;
            end
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_SCAN;
          end
        end
        S_RM_RD: begin
          if ((k_r + 1'b1) < cnt_r) begin
            state_r <= S_RM_WR;
          end else begin
            for (int i = 0; i <= MAX_ROWS; i++) begin
              if (CNT_W'(i) >= CNT_W'(row_r)) begin
                rs_r[i] <= rs_r[i] - 1'b1;
              end
            end
            cnt_r   <= cnt_r - 1'b1;
            state_r <= S_DONE;
          end
        end
        S_RM_WR: begin
          k_r     <= k_r + 1'b1;
          state_r <= S_RM_RD;
        end
        S_INS_RD: begin
          if (k_r > end_r) begin
            state_r <= S_INS_WR;
          end else begin
            for (int i = 0; i <= MAX_ROWS; i++) begin
              if (CNT_W'(i) >= CNT_W'(row_r)) begin
                rs_r[i] <= rs_r[i] + 1'b1;
              end
            end
            cnt_r   <= cnt_r + 1'b1;
            state_r <= S_DONE;
          end
        end
        S_INS_WR: begin
          k_r     <= k_r - 1'b1;
          state_r <= S_INS_RD;
        end
        S_P_ROW: begin
          if (prow_r == RSI_W'(MAX_ROWS)) begin
            rs_r[MAX_ROWS] <= dst_r;
            cnt_r          <= dst_r;
            state_r        <= S_DONE;
          end else begin
            end_r        <= rs_q;
            rs_r[prow_r] <= dst_r;
            state_r      <= S_P_RD;
          end
        end
        S_P_RD: begin
          if (k_r < end_r) begin
            state_r <= S_P_WR;
          end else begin
            prow_r  <= prow_r + 1'b1;
            state_r <= S_P_ROW;
          end
        end
        S_P_WR: begin
          if (ram_rdata.value != val_r) begin
            dst_r <= dst_r + 1'b1;
          end
          k_r     <= k_r + 1'b1;
          state_r <= S_P_RD;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= '{read_value: rd_r, in_range: ok_r,
                             entry_total: 9'(cnt_r)};
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
